// ----- rtl/bccp_pkg.sv -----
// Shared types and constants for the bulk cc/channel command parser.
package bccp_pkg;

  localparam logic [7:0] MAX_POTS = 8'd255;
  localparam logic [7:0] POT_COUNT_RESET = 8'd16;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PREFIX    = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_FEW       = 3'd4;

  localparam logic RK_STORE  = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  typedef struct packed {
    logic [7:0] command_byte;
    logic       command_end;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic [8:0] store_address;
    logic [6:0] store_data;
    logic [2:0] status_code;
    logic       last_of_run;
  } out_word_t;

  // Results caused by one byte: an optional write pair and an optional status.
  typedef struct packed {
    logic       wr;
    logic [7:0] pot;
    logic [6:0] chan;
    logic [6:0] cc;
    logic       st;
    logic [2:0] status;
  } bundle_t;

  // "SET_ALL"
  function automatic logic [7:0] lead_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h53;
      3'd1:    ch = 8'h45;
      3'd2:    ch = 8'h54;
      3'd3:    ch = 8'h5F;
      3'd4:    ch = 8'h41;
      3'd5:    ch = 8'h4C;
      3'd6:    ch = 8'h4C;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- rtl/bulk_cc_channel_command_parser.sv -----
// Accepted bytes wait in the input register, then their results are loaded into
// the result register. Throughput: one byte a cycle when it causes at most one
// result and the output does not stall; otherwise the input stalls until the
// single result register that serializes the words has handed them all out.
// Reset: asynchronous, active low; clears the parse state and sets pot_count to 16.
module bulk_cc_channel_command_parser
  import bccp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic       inq_valid_q, inq_valid_d;
  in_word_t   inq_word_q;
  logic [7:0] pot_count_q;
  logic       free;
  logic       step;
  logic       accept;
  bundle_t    bundle;

  assign cfg_ready_o = 1'b1;
  assign step        = inq_valid_q && free;
  assign in_stall_o  = inq_valid_q && !free;
  assign accept      = in_valid_i && !in_stall_o;
  assign inq_valid_d = accept ? 1'b1 : (step ? 1'b0 : inq_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      pot_count_q <= POT_COUNT_RESET;
    end else begin
      inq_valid_q <= inq_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pot_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inq_word_q <= in_word_i;
    end
  end

  bccp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step),
    .word_i      (inq_word_q),
    .pot_count_i (pot_count_q),
    .bundle_o    (bundle)
  );

  bccp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .bundle_i    (bundle),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- rtl/bccp_core.sv -----
// Parse state and single-byte step logic of the command parser.
module bccp_core
  import bccp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_en_i,
  input  in_word_t   word_i,
  input  logic [7:0] pot_count_i,
  output bundle_t    bundle_o
);

  localparam logic [1:0] PH_PREFIX   = 2'd0;
  localparam logic [1:0] PH_SKIP     = 2'd1;
  localparam logic [1:0] PH_SEGMENTS = 2'd2;
  localparam logic [1:0] PH_IGNORE   = 2'd3;

  localparam logic [1:0] FS_BLANKS = 2'd0;
  localparam logic [1:0] FS_DIGITS = 2'd1;
  localparam logic [1:0] FS_DONE   = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [2:0] pos_q, pos_d;
  logic [7:0] pots_q, pots_d;
  logic       in_chan_q, in_chan_d;
  logic [1:0] fstage_q, fstage_d;
  logic       fneg_q, fneg_d;
  logic [7:0] cc_q, cc_d;
  logic       ccneg_q, ccneg_d;
  logic [7:0] chan_q, chan_d;
  logic       seg_open_q, seg_open_d;
  logic [2:0] err_q, err_d;

  logic [7:0]  c;
  logic [7:0]  used;
  logic        is_blank, is_digit;
  logic [7:0]  v_sel, f_v;
  logic [1:0]  f_s;
  logic        f_n, go;
  logic [11:0] acc;
  logic        cc_ok, ch_ok;

  assign c        = word_i.command_byte;
  assign used     = (pot_count_i < MAX_POTS) ? pot_count_i : MAX_POTS;
  assign is_blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign v_sel    = in_chan_q ? chan_q : cc_q;
  // value*10 + digit, saturated at 255 below
  assign acc = ({4'd0, v_sel} << 3) + ({4'd0, v_sel} << 1) + {4'd0, c - CH_ZERO};
  assign cc_ok = (cc_q <= 8'd127) && !(ccneg_q && cc_q != 8'd0);
  assign ch_ok = !fneg_q && (chan_q >= 8'd1) && (chan_q <= 8'd16);

  // atol-style number feed for the field being read
  always_comb begin
    f_v = v_sel;
    f_s = fstage_q;
    f_n = fneg_q;
    go  = 1'b0;
    if (fstage_q == FS_BLANKS) begin
      if (is_blank) begin
        go = 1'b0;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        f_n = (c == CH_MINUS);
        f_s = FS_DIGITS;
      end else begin
        go = 1'b1;
      end
    end else if (fstage_q == FS_DIGITS) begin
      go = 1'b1;
    end
    if (go) begin
      if (is_digit) begin
        f_v = (acc > 12'd255) ? 8'hFF : acc[7:0];
        f_s = FS_DIGITS;
      end else begin
        f_s = FS_DONE;
      end
    end
  end

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    pots_d     = pots_q;
    in_chan_d  = in_chan_q;
    fstage_d   = fstage_q;
    fneg_d     = fneg_q;
    cc_d       = cc_q;
    ccneg_d    = ccneg_q;
    chan_d     = chan_q;
    seg_open_d = seg_open_q;
    err_d      = err_q;
    bundle_o   = '0;
    bundle_o.pot  = pots_q;
    bundle_o.chan = chan_q[6:0];
    bundle_o.cc   = cc_q[6:0];

    case (phase_q)
      PH_PREFIX: begin
        if (c == lead_char(pos_q)) begin
          pos_d = pos_q + 3'd1;
          if (pos_q == 3'd6) begin
            phase_d = PH_SKIP;
          end
        end else begin
          err_d   = ST_PREFIX;
          phase_d = PH_IGNORE;
        end
      end
      PH_SKIP: begin
        phase_d    = PH_SEGMENTS;
        in_chan_d  = 1'b0;
        fstage_d   = FS_BLANKS;
        fneg_d     = 1'b0;
        cc_d       = '0;
        ccneg_d    = 1'b0;
        chan_d     = '0;
        seg_open_d = 1'b0;
      end
      PH_SEGMENTS: begin
        if (pots_q < used) begin
          seg_open_d = 1'b1;
          if (c == CH_SEMI) begin
            if (!in_chan_q) begin
              err_d   = ST_MALFORMED;
              phase_d = PH_IGNORE;
            end else if (!cc_ok || !ch_ok) begin
              err_d   = ST_RANGE;
              phase_d = PH_IGNORE;
            end else begin
              bundle_o.wr = 1'b1;
              pots_d      = pots_q + 8'd1;
              in_chan_d   = 1'b0;
              fstage_d    = FS_BLANKS;
              fneg_d      = 1'b0;
              cc_d        = '0;
              ccneg_d     = 1'b0;
              chan_d      = '0;
              seg_open_d  = 1'b0;
            end
          end else if (c == CH_COMMA && !in_chan_q) begin
            ccneg_d   = fneg_q;
            in_chan_d = 1'b1;
            fstage_d  = FS_BLANKS;
            fneg_d    = 1'b0;
          end else begin
            fstage_d = f_s;
            fneg_d   = f_n;
            if (in_chan_q) begin
              chan_d = f_v;
            end else begin
              cc_d = f_v;
            end
          end
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase

    if (word_i.command_end) begin
      bundle_o.st = 1'b1;
      if (err_d != ST_OK) begin
        bundle_o.status = err_d;
      end else if (phase_d == PH_PREFIX) begin
        bundle_o.status = ST_PREFIX;
      end else if (pots_d >= used) begin
        bundle_o.status = ST_OK;
      end else if (seg_open_d) begin
        bundle_o.status = ST_MALFORMED;
      end else begin
        bundle_o.status = ST_FEW;
      end
      phase_d    = PH_PREFIX;
      pos_d      = '0;
      pots_d     = '0;
      in_chan_d  = 1'b0;
      fstage_d   = FS_BLANKS;
      fneg_d     = 1'b0;
      cc_d       = '0;
      ccneg_d    = 1'b0;
      chan_d     = '0;
      seg_open_d = 1'b0;
      err_d      = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PREFIX;
      pos_q      <= '0;
      pots_q     <= '0;
      in_chan_q  <= 1'b0;
      fstage_q   <= FS_BLANKS;
      fneg_q     <= 1'b0;
      cc_q       <= '0;
      ccneg_q    <= 1'b0;
      chan_q     <= '0;
      seg_open_q <= 1'b0;
      err_q      <= ST_OK;
    end else if (step_en_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      pots_q     <= pots_d;
      in_chan_q  <= in_chan_d;
      fstage_q   <= fstage_d;
      fneg_q     <= fneg_d;
      cc_q       <= cc_d;
      ccneg_q    <= ccneg_d;
      chan_q     <= chan_d;
      seg_open_q <= seg_open_d;
      err_q      <= err_d;
    end
  end

endmodule

// ----- rtl/bccp_out.sv -----
// Result register: holds one byte's results and hands them out one word a cycle while the output is not stalled.
module bccp_out
  import bccp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  bundle_t   bundle_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [1:0] wr_pend_q, wr_pend_d;  // writes left: 2 = channel next, 1 = cc next
  logic       st_pend_q, st_pend_d;
  logic [7:0] pot_q;
  logic [6:0] chan_q;
  logic [6:0] cc_q;
  logic [2:0] status_q;
  logic       pop;

  assign out_valid_o = (wr_pend_q != 2'd0) || st_pend_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = !out_valid_o || (pop && out_word_o.last_of_run);

  always_comb begin
    out_word_o = '0;
    if (wr_pend_q == 2'd2) begin
      out_word_o.result_kind   = RK_STORE;
      out_word_o.store_address = {pot_q, 1'b0};
      out_word_o.store_data    = chan_q;
      out_word_o.last_of_run   = 1'b0;
    end else if (wr_pend_q == 2'd1) begin
      out_word_o.result_kind   = RK_STORE;
      out_word_o.store_address = {pot_q, 1'b1};
      out_word_o.store_data    = cc_q;
      out_word_o.last_of_run   = !st_pend_q;
    end else begin
      out_word_o.result_kind = RK_STATUS;
      out_word_o.status_code = status_q;
      out_word_o.last_of_run = 1'b1;
    end
  end

  always_comb begin
    wr_pend_d = wr_pend_q;
    st_pend_d = st_pend_q;
    if (load_i) begin
      wr_pend_d = bundle_i.wr ? 2'd2 : 2'd0;
      st_pend_d = bundle_i.st;
    end else if (pop) begin
      if (wr_pend_q != 2'd0) begin
        wr_pend_d = wr_pend_q - 2'd1;
      end else begin
        st_pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 2'd0;
      st_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= wr_pend_d;
      st_pend_q <= st_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pot_q    <= bundle_i.pot;
      chan_q   <= bundle_i.chan;
      cc_q     <= bundle_i.cc;
      status_q <= bundle_i.status;
    end
  end

endmodule

// ----- rtl/bccp_checker.sv -----
// Port-level checks for the command parser, bound to the top level.
module bccp_checker
  import bccp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input out_word_t  out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // a channel write is always followed at once by its cc write
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.result_kind == RK_STORE &&
    !out_word_o.store_address[0]
    |=> out_valid_o && out_word_o.result_kind == RK_STORE && out_word_o.store_address[0])
    else $error("cc write missing after channel write");

  a_status_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.result_kind == RK_STORE &&
    out_word_o.store_address[0] && !out_word_o.last_of_run
    |=> out_valid_o && out_word_o.result_kind == RK_STATUS)
    else $error("status missing after cc write");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.result_kind == RK_STATUS |-> out_word_o.last_of_run)
    else $error("status word not last of run");

endmodule

bind bulk_cc_channel_command_parser bccp_checker u_checker (.*);

// ----- sim/tb.sv -----
// Testbench for the bulk cc/channel command parser: directed table plus random commands.
`timescale 1ns / 1ps

module tb;
  import bccp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 32;
  localparam logic [55:0] PREFIX_TEXT = "SET_ALL";
  localparam int PHASE_COUNTS [6] = '{3, 0, 255, 1, 5, 2};

  typedef enum logic [1:0] {P_PREFIX, P_SKIP, P_SEGMENTS, P_IGNORE} parse_phase_e;
  typedef enum logic [1:0] {F_BLANKS, F_DIGITS, F_DONE} field_stage_e;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       typed;
    logic [2:0] st;
  } row_t;

  // Run with pot_count = 1. Status is typed in only where it is obvious.
  localparam row_t DIRECTED [25] = '{
    '{8'hFF, 1'b1, 1'b1, ST_PREFIX},
    '{8'h00, 1'b1, 1'b1, ST_PREFIX},
    '{"S", 1'b0, 1'b0, ST_OK}, '{"E", 1'b0, 1'b0, ST_OK}, '{"T", 1'b0, 1'b0, ST_OK},
    '{"_", 1'b0, 1'b0, ST_OK}, '{"A", 1'b0, 1'b0, ST_OK}, '{"L", 1'b0, 1'b0, ST_OK},
    '{"L", 1'b1, 1'b1, ST_FEW},
    '{"S", 1'b0, 1'b0, ST_OK}, '{"E", 1'b0, 1'b0, ST_OK}, '{"T", 1'b0, 1'b0, ST_OK},
    '{"_", 1'b0, 1'b0, ST_OK}, '{"A", 1'b0, 1'b0, ST_OK}, '{"L", 1'b0, 1'b0, ST_OK},
    '{"L", 1'b0, 1'b0, ST_OK},
    '{8'hFF, 1'b0, 1'b0, ST_OK},
    '{"-", 1'b0, 1'b0, ST_OK}, '{"0", 1'b0, 1'b0, ST_OK}, '{",", 1'b0, 1'b0, ST_OK},
    '{"+", 1'b0, 1'b0, ST_OK}, '{"1", 1'b0, 1'b0, ST_OK}, '{"6", 1'b0, 1'b0, ST_OK},
    '{";", 1'b0, 1'b0, ST_OK},
    '{8'h7F, 1'b1, 1'b1, ST_OK}
  };

  logic       clk_i = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  // parser shadow state
  parse_phase_e p_phase;
  field_stage_e p_stage;
  logic [2:0]   p_pos;
  logic [7:0]   p_stored;
  logic         p_in_chan;
  logic         p_neg;
  logic [7:0]   p_cc;
  logic         p_cc_neg;
  logic [7:0]   p_chan;
  logic         p_open;
  logic [2:0]   p_err;
  logic [7:0]   p_count;

  out_word_t  step_words [3];
  out_word_t  expected_words [$];
  out_word_t  oldest_word;
  logic [7:0] cmd_text [$];
  int         fail_count = 0;
  int         cycle_count = 0;
  int         rx_hold = 0;
  int         rx_max = 18;
  int         tx_max = 18;

  bulk_cc_channel_command_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function void queue_word(input out_word_t w);
    expected_words = {expected_words, w};
  endfunction

  function void queue_char(input logic [7:0] ch);
    cmd_text = {cmd_text, ch};
  endfunction

  function void start_segment();
    p_in_chan = 1'b0;
    p_stage   = F_BLANKS;
    p_neg     = 1'b0;
    p_cc      = '0;
    p_cc_neg  = 1'b0;
    p_chan    = '0;
    p_open    = 1'b0;
  endfunction

  function void clear_parse();
    start_segment();
    p_phase  = P_PREFIX;
    p_pos    = '0;
    p_stored = '0;
    p_err    = ST_OK;
  endfunction

  function void abort_parse(input logic [2:0] code);
    p_err   = code;
    p_phase = P_IGNORE;
  endfunction

  // atol-style digit accumulation, saturating at 255
  function logic [7:0] accumulate(input logic [7:0] c, input logic [7:0] v);
    int t;
    if (p_stage == F_BLANKS) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return v;
      if (c == CH_PLUS || c == CH_MINUS) begin
        p_neg   = (c == CH_MINUS);
        p_stage = F_DIGITS;
        return v;
      end
      p_stage = F_DIGITS;
    end
    if (p_stage == F_DIGITS) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t = int'(v) * 10 + int'(c - CH_ZERO);
        return (t > 255) ? 8'd255 : 8'(t);
      end
      p_stage = F_DONE;
    end
    return v;
  endfunction

  function int parse_byte(input in_word_t w);
    logic [7:0] c;
    logic [7:0] used;
    logic       cc_ok;
    logic       ch_ok;
    logic [2:0] st;
    int         n;
    c    = w.command_byte;
    used = (p_count < MAX_POTS) ? p_count : MAX_POTS;
    n    = 0;
    case (p_phase)
      P_PREFIX: begin
        if (c == PREFIX_TEXT[8 * (6 - int'(p_pos)) +: 8]) begin
          p_pos = p_pos + 3'd1;
          if (p_pos >= 3'd7) p_phase = P_SKIP;
        end else begin
          abort_parse(ST_PREFIX);
        end
      end
      P_SKIP: begin
        p_phase = P_SEGMENTS;
        start_segment();
      end
      P_SEGMENTS: begin
        if (p_stored < used) begin
          p_open = 1'b1;
          if (c == CH_SEMI) begin
            cc_ok = (p_cc <= 8'd127) && !(p_cc_neg && p_cc != 8'd0);
            ch_ok = !p_neg && p_chan >= 8'd1 && p_chan <= 8'd16;
            if (!p_in_chan) begin
              abort_parse(ST_MALFORMED);
            end else if (!cc_ok || !ch_ok) begin
              abort_parse(ST_RANGE);
            end else begin
              step_words[0] = {RK_STORE, p_stored, 1'b0, p_chan[6:0], ST_OK, 1'b0};
              step_words[1] = {RK_STORE, p_stored, 1'b1, p_cc[6:0], ST_OK, 1'b0};
              n = 2;
              p_stored = p_stored + 8'd1;
              start_segment();
            end
          end else if (c == CH_COMMA && !p_in_chan) begin
            p_cc_neg  = p_neg;
            p_in_chan = 1'b1;
            p_stage   = F_BLANKS;
            p_neg     = 1'b0;
          end else if (p_in_chan) begin
            p_chan = accumulate(c, p_chan);
          end else begin
            p_cc = accumulate(c, p_cc);
          end
        end
      end
      default: ;
    endcase
    if (w.command_end) begin
      if (p_err != ST_OK) st = p_err;
      else if (p_phase == P_PREFIX) st = ST_PREFIX;
      else if (p_stored >= used) st = ST_OK;
      else if (p_open) st = ST_MALFORMED;
      else st = ST_FEW;
      step_words[n] = {RK_STATUS, 9'd0, 7'd0, st, 1'b0};
      n++;
      clear_parse();
    end
    if (n > 0) step_words[n - 1].last_of_run = 1'b1;
    return n;
  endfunction

  task send_byte(input in_word_t w, input bit typed, input logic [2:0] typed_st);
    int gap;
    int n;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    n = parse_byte(w);
    if (typed) begin
      queue_word({RK_STATUS, 9'd0, 7'd0, typed_st, 1'b1});
    end else begin
      for (int k = 0; k < n; k++) queue_word(step_words[k]);
    end
  endtask

  task set_pot_count(input logic [7:0] v);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    p_count = v;
  endtask

  task add_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i]);
  endtask

  // one number field with random blanks, sign, value and trailing junk
  task add_field(input bit chan);
    int k;
    int v;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2))
        queue_char($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
    end
    k = $urandom_range(0, 9);
    if (k == 0) queue_char(CH_PLUS);
    else if (k == 1) queue_char(CH_MINUS);
    k = $urandom_range(0, 15);
    if (k == 0) begin
      v = $urandom_range(0, 99999);
    end else if (k == 1) begin
      v = -1;
    end else if (k == 2) begin
      queue_char(CH_ZERO);
      v = $urandom_range(0, 16);
    end else if (k == 3) begin
      v = chan ? ($urandom_range(0, 1) ? 0 : 17) : $urandom_range(128, 255);
    end else begin
      v = chan ? $urandom_range(1, 16) : $urandom_range(0, 127);
    end
    if (v >= 0) add_text($sformatf("%0d", v));
    if ($urandom_range(0, 11) == 0) queue_char(chan ? CH_COMMA : "x");
  endtask

  task build_command(input logic [7:0] count);
    int r;
    int segs;
    cmd_text.delete();
    r = $urandom_range(0, 19);
    if (r == 0) begin
      repeat ($urandom_range(1, 10)) queue_char(8'($urandom_range(0, 255)));
    end else begin
      add_text("SET_ALL");
      if (r == 1) cmd_text[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
      if (r == 2) begin
        repeat ($urandom_range(1, 6)) void'(cmd_text.pop_back());
      end else begin
        queue_char(8'($urandom_range(0, 255)));
        if (count == MAX_POTS) segs = $urandom_range(0, 12);
        else if ($urandom_range(0, 3) == 0) segs = $urandom_range(0, int'(count) + 2);
        else segs = int'(count);
        repeat (segs) begin
          add_field(1'b0);
          if ($urandom_range(0, 24) != 0) queue_char(CH_COMMA);
          add_field(1'b1);
          if ($urandom_range(0, 24) != 0) queue_char(CH_SEMI);
        end
        case ($urandom_range(0, 3))
          1: repeat ($urandom_range(1, 3)) queue_char(8'($urandom_range(0, 255)));
          2: add_field(1'b0);
          default: ;
        endcase
      end
    end
  endtask

  task check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch in %s: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // output checker and random receiver stall
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected word: expected none, got %h", $time, out_word);
          fail_count++;
        end else begin
          oldest_word = expected_words.pop_front();
          check_field("result_kind", oldest_word.result_kind, out_word.result_kind);
          check_field("store_address", oldest_word.store_address, out_word.store_address);
          check_field("store_data", oldest_word.store_data, out_word.store_data);
          check_field("status_code", oldest_word.status_code, out_word.status_code);
          check_field("last_of_run", oldest_word.last_of_run, out_word.last_of_run);
        end
        rx_hold = $urandom_range(0, rx_max);
      end else if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
      end
      out_stall <= (rx_hold > 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int         sent;
    logic [7:0] count;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    clear_parse();
    p_count = POT_COUNT_RESET;
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    set_pot_count(8'd1);
    for (int i = 0; i < 25; i++)
      send_byte({DIRECTED[i].b, DIRECTED[i].e}, DIRECTED[i].typed, DIRECTED[i].st);

    for (int ph = 0; ph < 6; ph++) begin
      count = (ph == 5) ? 8'($urandom_range(2, 8)) : 8'(PHASE_COUNTS[ph]);
      set_pot_count(count);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_command(count);
        // some commands run with no idling on either side
        tx_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
        rx_max <= ($urandom_range(0, 3) == 0) ? 0 : 18;
        for (int i = 0; i < cmd_text.size(); i++)
          send_byte({cmd_text[i], i == cmd_text.size() - 1}, 1'b0, ST_OK);
        sent += cmd_text.size();
      end
    end

    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
